[hw/rtl/shltok_pkg.sv]
// Shared types, character codes and limits for the shell line tokenizer.
package shltok_pkg;

  localparam int POS_W   = 12;
  localparam int ARG_W   = 6;
  localparam int GRP_W   = 4;
  localparam int CMD_W   = 4;
  localparam int CH_W    = 8;
  localparam int OUT_W   = 48;

  localparam logic [POS_W-1:0] POS_LIMIT   = 12'd4095;
  localparam logic [ARG_W-1:0] ARG_LIMIT   = 6'd63;
  localparam logic [GRP_W-1:0] GROUP_LIMIT = 4'd15;
  localparam logic [CMD_W-1:0] CMD_LIMIT   = 4'd15;

  localparam logic [CH_W-1:0] CH_END   = 8'h00;
  localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CH_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [CH_W-1:0] CH_RIN   = 8'h3C;
  localparam logic [CH_W-1:0] CH_ROUT  = 8'h3E;
  localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;

  localparam logic [CH_W-1:0] DELIM_FIRST_RST  = 8'd32;
  localparam logic [CH_W-1:0] DELIM_SECOND_RST = 8'd9;
  localparam logic [CH_W-1:0] DELIM_THIRD_RST  = 8'd10;

  localparam logic [1:0] REG_DELIM_FIRST  = 2'd0;
  localparam logic [1:0] REG_DELIM_SECOND = 2'd1;
  localparam logic [1:0] REG_DELIM_THIRD  = 2'd2;

  localparam logic [1:0] BND_NONE = 2'd0;
  localparam logic [1:0] BND_PIPE = 2'd1;
  localparam logic [1:0] BND_SEMI = 2'd2;
  localparam logic [1:0] BND_END  = 2'd3;

  localparam logic [1:0] ARG_PLAIN = 2'd0;
  localparam logic [1:0] ARG_RIN   = 2'd1;
  localparam logic [1:0] ARG_ROUT  = 2'd2;

  typedef enum logic [2:0] {
    CLS_TEXT,
    CLS_QUOTE,
    CLS_SEP,
    CLS_PIPE,
    CLS_SEMI,
    CLS_RIN,
    CLS_ROUT,
    CLS_END
  } char_class_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_count;
    logic             quoting;
    logic             arg_open;
    logic             pending_in;
    logic             pending_out;
    logic [POS_W-1:0] start_pos;
    logic [ARG_W-1:0] arg_count;
    logic [GRP_W-1:0] group_count;
    logic [CMD_W-1:0] cmd_count;
  } tok_state_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             cut;
    logic             arg_valid;
    logic [1:0]       arg_kind;
    logic [POS_W-1:0] arg_first;
    logic [ARG_W-1:0] arg_index;
    logic [1:0]       boundary;
    logic [GRP_W-1:0] group_number;
    logic [CMD_W-1:0] command_number;
    logic             overflow;
  } tok_result_t;

endpackage

[hw/rtl/shltok_step.sv]
// Per-byte classification, result and next tokenizer state.
module shltok_step (
  input  shltok_pkg::tok_state_t            state,
  input  logic [shltok_pkg::CH_W-1:0]       ch,
  input  logic [shltok_pkg::CH_W-1:0]       delim_first,
  input  logic [shltok_pkg::CH_W-1:0]       delim_second,
  input  logic [shltok_pkg::CH_W-1:0]       delim_third,
  output shltok_pkg::char_class_t           cls,
  output shltok_pkg::tok_state_t            state_next,
  output shltok_pkg::tok_result_t           res
);

  logic is_delim;

  assign is_delim = (delim_first != '0 && ch == delim_first) ||
                    (delim_second != '0 && ch == delim_second) ||
                    (delim_third != '0 && ch == delim_third);

  always_comb begin
    if (ch == shltok_pkg::CH_END) begin
      cls = shltok_pkg::CLS_END;
    end else if (!state.quoting && ch == shltok_pkg::CH_SEMI) begin
      cls = shltok_pkg::CLS_SEMI;
    end else if (!state.quoting && ch == shltok_pkg::CH_PIPE) begin
      cls = shltok_pkg::CLS_PIPE;
    end else if (!state.quoting && ch == shltok_pkg::CH_RIN) begin
      cls = shltok_pkg::CLS_RIN;
    end else if (!state.quoting && ch == shltok_pkg::CH_ROUT) begin
      cls = shltok_pkg::CLS_ROUT;
    end else if (ch == shltok_pkg::CH_QUOTE) begin
      cls = shltok_pkg::CLS_QUOTE;
    end else if (!state.quoting && is_delim) begin
      cls = shltok_pkg::CLS_SEP;
    end else begin
      cls = shltok_pkg::CLS_TEXT;
    end
  end

  always_comb begin
    state_next = state;
    res = '0;
    res.position       = state.pos_count;
    res.group_number   = state.group_count;
    res.command_number = state.cmd_count;
    res.cut = (cls != shltok_pkg::CLS_TEXT) && (cls != shltok_pkg::CLS_END);

    // close the open argument
    if (cls != shltok_pkg::CLS_TEXT && cls != shltok_pkg::CLS_QUOTE && state.arg_open) begin
      res.arg_valid = 1'b1;
      res.arg_first = state.start_pos;
      if (state.pending_in) begin
        res.arg_kind = shltok_pkg::ARG_RIN;
        state_next.pending_in = 1'b0;
      end else if (state.pending_out) begin
        res.arg_kind = shltok_pkg::ARG_ROUT;
        state_next.pending_out = 1'b0;
      end else begin
        res.arg_kind  = shltok_pkg::ARG_PLAIN;
        res.arg_index = state.arg_count;
        if (state.arg_count < shltok_pkg::ARG_LIMIT) begin
          state_next.arg_count = state.arg_count + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
      end
      state_next.arg_open = 1'b0;
    end

    case (cls)
      shltok_pkg::CLS_TEXT: begin
        if (!state.arg_open) begin
          state_next.start_pos = state.pos_count;
          state_next.arg_open  = 1'b1;
        end
      end
      shltok_pkg::CLS_QUOTE: begin
        if (state.quoting) begin
          state_next.quoting = 1'b0;
        end else begin
          state_next.quoting = 1'b1;
          state_next.start_pos = (state.pos_count < shltok_pkg::POS_LIMIT) ?
                                 state.pos_count + 1'b1 : shltok_pkg::POS_LIMIT;
        end
      end
      shltok_pkg::CLS_RIN: begin
        state_next.pending_in = 1'b1;
      end
      shltok_pkg::CLS_ROUT: begin
        state_next.pending_out = 1'b1;
      end
      shltok_pkg::CLS_PIPE: begin
        res.boundary = shltok_pkg::BND_PIPE;
        state_next.arg_count = '0;
        if (state.cmd_count < shltok_pkg::CMD_LIMIT) begin
          state_next.cmd_count = state.cmd_count + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
      end
      shltok_pkg::CLS_SEMI: begin
        res.boundary = shltok_pkg::BND_SEMI;
        state_next.arg_count = '0;
        state_next.cmd_count = '0;
        if (state.group_count < shltok_pkg::GROUP_LIMIT) begin
          state_next.group_count = state.group_count + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cls == shltok_pkg::CLS_END) begin
      res.boundary = shltok_pkg::BND_END;
      state_next = '0;
    end else if (state.pos_count < shltok_pkg::POS_LIMIT) begin
      state_next.pos_count = state.pos_count + 1'b1;
    end else begin
      res.overflow = 1'b1;
    end
  end

endmodule

[hw/rtl/shell_line_tokenizer_core.sv]
// Top level: stream ports, delimiter registers and tokenizer state.
// A byte accepted into the input register has its result written to the output register on advance.
// One byte per cycle unless the output stalls; each state update is one combinational step.
// A stalled output holds its result while the input register keeps one further byte.
// Reset clears the tokenizer state and both valid flags, and loads delimiters 32, 9 and 10.
module shell_line_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [11:0] position, [12] cut, [13] arg_valid,
                                      // [15:14] arg_kind, [27:16] arg_first,
                                      // [33:28] arg_index, [35:34] boundary,
                                      // [39:36] group_number, [43:40] command_number,
                                      // [44] overflow, [47:45] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [shltok_pkg::CH_W-1:0] delim_first;
  logic [shltok_pkg::CH_W-1:0] delim_second;
  logic [shltok_pkg::CH_W-1:0] delim_third;

  logic                            in_valid;
  logic [shltok_pkg::CH_W-1:0]     in_ch;
  logic                            out_valid;
  logic [shltok_pkg::OUT_W-1:0]    out_data;
  shltok_pkg::tok_state_t          state;
  shltok_pkg::tok_state_t          state_next;
  shltok_pkg::tok_result_t         res;
  shltok_pkg::char_class_t         cls;
  logic                            advance;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_first  <= shltok_pkg::DELIM_FIRST_RST;
      delim_second <= shltok_pkg::DELIM_SECOND_RST;
      delim_third  <= shltok_pkg::DELIM_THIRD_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        shltok_pkg::REG_DELIM_FIRST:  delim_first  <= pwdata[7:0];
        shltok_pkg::REG_DELIM_SECOND: delim_second <= pwdata[7:0];
        shltok_pkg::REG_DELIM_THIRD:  delim_third  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      shltok_pkg::REG_DELIM_FIRST:  prdata = {24'd0, delim_first};
      shltok_pkg::REG_DELIM_SECOND: prdata = {24'd0, delim_second};
      shltok_pkg::REG_DELIM_THIRD:  prdata = {24'd0, delim_third};
      default:                      prdata = '0;
    endcase
  end

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  shltok_step u_step (
    .state        (state),
    .ch           (in_ch),
    .delim_first  (delim_first),
    .delim_second (delim_second),
    .delim_third  (delim_third),
    .cls          (cls),
    .state_next   (state_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      state     <= state_next;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'd0, res.overflow, res.command_number, res.group_number, res.boundary,
                   res.arg_index, res.arg_first, res.arg_kind, res.arg_valid, res.cut,
                   res.position};
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && cls == shltok_pkg::CLS_END) |=>
      (state.pos_count == '0 && !state.quoting && !state.arg_open && state.group_count == '0))
    else $error("state not cleared after end of line");

  a_no_arg_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data[13]) |-> (out_data[33:14] == '0))
    else $error("argument fields set without a finished argument");

  a_redirect_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[15:14] != shltok_pkg::ARG_PLAIN) |-> (out_data[33:28] == '0))
    else $error("redirect target carries an argument index");

  a_sep_closes: assert property (@(posedge clk) disable iff (rst)
    (advance && cls != shltok_pkg::CLS_TEXT && cls != shltok_pkg::CLS_QUOTE) |=>
      !state.arg_open)
    else $error("argument left open after a closing byte");

endmodule
